// ----- rtl/core/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// lbc_pkg
// Types and constants of the systematic linear block code codec.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int DATA_BITS   = 8;
  localparam int PARITY_BITS = 6;
  localparam int CODE_BITS   = DATA_BITS + PARITY_BITS;
  localparam int TBL_DEPTH   = 1 << PARITY_BITS;
  localparam int MATRIX_W    = 48;
  localparam int DIST_W      = 4;

  typedef logic [DATA_BITS-1:0]   data_t;
  typedef logic [PARITY_BITS-1:0] par_t;
  typedef logic [CODE_BITS-1:0]   code_t;
  typedef logic [MATRIX_W-1:0]    matrix_t;
  typedef logic [DIST_W-1:0]      dist_t;

  localparam matrix_t MATRIX_RESET = 48'd281440346423166;
  localparam dist_t   DIST_MAX     = '1;

  typedef enum logic [1:0] {
    OP_ENCODE  = 2'd0,
    OP_DECODE  = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NONE    = 2'd3
  } lbc_op_t;

  typedef struct packed {
    lbc_op_t opcode;
    data_t   data_word;
    code_t   received_word;
  } lbc_in_t;

  typedef struct packed {
    code_t codeword;
    data_t decoded_data;
    par_t  syndrome;
    logic  corrected;
    dist_t min_distance;
  } lbc_out_t;

endpackage

// ----- rtl/core/lbc_ram.sv -----
// ----------------------------------------------------------------------------
// lbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbc_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/linear_block_code_codec.sv -----
// ----------------------------------------------------------------------------
// linear_block_code_codec
// Systematic (14,8) binary block code: encode, syndrome decode with a coset
// leader table, and table rebuild with minimum distance report.
// ----------------------------------------------------------------------------
// Encode and decode beats flow one per cycle through two stages (syndrome and
// table read, then the result register), and a new beat is taken every cycle
// while the result side keeps up. A rebuild beat blocks the input after it is
// taken, until its table sweep is done: every nonzero 14-bit error pattern
// passes once through a read-modify-write of the 64-entry coset table RAM,
// one pattern per cycle, with forwarding of the previous write. The table
// reads as all zero after reset and at the start of each rebuild through
// per-entry valid flags, so there is no clearing pass. Writing the parity
// matrix does not rebuild the table.
// ----------------------------------------------------------------------------
module linear_block_code_codec
  import lbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lbc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lbc_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  matrix_t  cfg_data
);

  function automatic par_t parity_of(data_t d, matrix_t m);
    par_t par;
    par = '0;
    for (int p = 0; p < PARITY_BITS; p++) begin
      for (int i = 0; i < DATA_BITS; i++) begin
        par[p] = par[p] ^ (d[i] & m[i*PARITY_BITS+p]);
      end
    end
    return par;
  endfunction

  function automatic par_t syn_of(code_t w, matrix_t m);
    return parity_of(w[DATA_BITS-1:0], m) ^ w[CODE_BITS-1:DATA_BITS];
  endfunction

  function automatic dist_t pop_of(code_t w);
    dist_t n;
    n = '0;
    for (int i = 0; i < CODE_BITS; i++) begin
      n = n + dist_t'(w[i]);
    end
    return n;
  endfunction

  matrix_t              mat_r;
  logic [TBL_DEPTH-1:0] vld_r;
  logic                 s1_v_r;
  code_t                cnt_r;
  logic                 s2_v_r;
  code_t                s2_pat_r;
  par_t                 s2_syn_r;
  logic                 wr_v_r;
  par_t                 wr_addr_r;
  code_t                wr_data_r;
  dist_t                dist_r;
  logic                 p_v_r;
  lbc_op_t              p_op_r;
  data_t                p_data_r;
  code_t                p_recv_r;
  par_t                 p_syn_r;
  logic                 out_v_r;
  lbc_out_t             out_r;

  logic     in_acc;
  logic     start;
  logic     sweep_busy;
  logic     p_adv;
  par_t     in_syn;
  par_t     s1_syn;
  logic     ram_re;
  par_t     ram_raddr;
  code_t    ram_rdata;
  logic     fwd_hit;
  logic     cur_v;
  code_t    cur;
  logic     keep;
  logic     dist_upd;
  logic [DIST_W:0] cand;
  code_t    leader;
  lbc_out_t res;

  assign cfg_ready  = 1'b1;
  assign sweep_busy = s1_v_r | s2_v_r;
  assign p_adv      = p_v_r && (!out_v_r || out_ready) &&
                      !(p_op_r == OP_REBUILD && sweep_busy);
  assign in_ready   = !sweep_busy && (!p_v_r || p_adv);
  assign in_acc     = in_valid & in_ready;
  assign start      = in_acc && (in_data.opcode == OP_REBUILD);

  assign in_syn    = syn_of(in_data.received_word, mat_r);
  assign s1_syn    = syn_of(cnt_r, mat_r);
  assign ram_re    = s1_v_r | in_acc;
  assign ram_raddr = s1_v_r ? s1_syn : in_syn;

  assign fwd_hit = wr_v_r && (wr_addr_r == s2_syn_r);
  assign cur_v   = fwd_hit | vld_r[s2_syn_r];
  assign cur     = fwd_hit ? wr_data_r : ram_rdata;
  assign keep    = s2_v_r && (s2_syn_r != '0) &&
                   (!cur_v || (pop_of(s2_pat_r) < pop_of(cur)));

  assign cand     = {1'b0, pop_of(s2_pat_r)} +
                    {1'b0, pop_of({{DATA_BITS{1'b0}}, s2_syn_r})};
  assign dist_upd = s2_v_r && (s2_pat_r[CODE_BITS-1:DATA_BITS] == '0) &&
                    (cand < {1'b0, dist_r});

  lbc_ram #(
    .WIDTH (CODE_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (keep),
    .waddr (s2_syn_r),
    .wdata (s2_pat_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign leader = vld_r[p_syn_r] ? ram_rdata : '0;

  always_comb begin
    res = '0;
    unique case (p_op_r)
      OP_ENCODE: begin
        res.codeword = {parity_of(p_data_r, mat_r), p_data_r};
      end
      OP_DECODE: begin
        res.syndrome = p_syn_r;
        if (p_syn_r == '0) begin
          res.decoded_data = p_recv_r[DATA_BITS-1:0];
        end else begin
          res.decoded_data = p_recv_r[DATA_BITS-1:0] ^ leader[DATA_BITS-1:0];
          res.corrected    = vld_r[p_syn_r];
        end
      end
      OP_REBUILD: begin
        res.min_distance = dist_r;
      end
      OP_NONE: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r   <= MATRIX_RESET;
      vld_r   <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      wr_v_r  <= 1'b0;
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mat_r <= cfg_data;
      end
      if (start) begin
        s1_v_r <= 1'b1;
      end else if (s1_v_r && (cnt_r == '1)) begin
        s1_v_r <= 1'b0;
      end
      s2_v_r <= s1_v_r;
      wr_v_r <= keep;
      if (start) begin
        vld_r <= '0;
      end else if (keep) begin
        vld_r[s2_syn_r] <= 1'b1;
      end
      if (in_acc) begin
        p_v_r <= 1'b1;
      end else if (p_adv) begin
        p_v_r <= 1'b0;
      end
      if (p_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= code_t'(1);
    end else if (s1_v_r) begin
      cnt_r <= cnt_r + code_t'(1);
    end
    s2_pat_r  <= cnt_r;
    s2_syn_r  <= s1_syn;
    wr_addr_r <= s2_syn_r;
    wr_data_r <= s2_pat_r;
    if (start) begin
      dist_r <= DIST_MAX;
    end else if (dist_upd) begin
      dist_r <= cand[DIST_W-1:0];
    end
    if (in_acc) begin
      p_op_r   <= in_data.opcode;
      p_data_r <= in_data.data_word;
      p_recv_r <= in_data.received_word;
      p_syn_r  <= in_syn;
    end
    if (p_adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_busy |-> !in_ready)
    else $error("input beat taken during table sweep");

  a_table_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (vld_r == '0))
    else $error("table flags not cleared at rebuild start");

  a_leader_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
    keep |-> (syn_of(s2_pat_r, mat_r) == s2_syn_r))
    else $error("coset leader written under wrong syndrome");

  a_corr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.corrected) |-> (out_r.syndrome != '0))
    else $error("correction flagged with zero syndrome");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(s1_v_r))
    else $error("sweep compare stage without read stage");

endmodule
